// ===== hw/rtl/ppf_pkg.sv =====
package ppf_pkg;

  localparam int GEOM_STAGES  = 3;
  localparam int FORCE_STAGES = 7;
  localparam int SQ_W         = 23;
  localparam int RAD_W        = 46;
  localparam int Q_W          = 27;
  localparam int NUM_W        = 55;
  localparam int CFG_IDX_W    = 3;
  localparam int RECIP_SH     = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 3'd4;

  localparam logic [33:0] REPEL_Q     = 34'd102400;
  localparam logic [33:0] NEAR_Q      = 34'd1638400;
  localparam logic [23:0] FIVE_Q16    = 24'd327680;
  localparam logic [23:0] FIFTY_Q16   = 24'd3276800;
  localparam logic [23:0] THIRTY_Q16  = 24'd1966080;
  localparam logic [21:0] RECIP30     = 22'd2236963;
  localparam logic [15:0] SPEED_RESET = 16'd256;

  typedef struct packed {
    logic signed [15:0] self_x;
    logic signed [15:0] self_y;
    logic signed [15:0] other_x;
    logic signed [15:0] other_y;
    logic [1:0]         self_kind;
    logic [1:0]         other_kind;
  } ppf_req_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               applied;
  } ppf_res_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [1:0]         self_kind;
    logic [1:0]         other_kind;
    logic               zero;
    logic               repel;
    logic               near;
  } ppf_geo_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [SQ_W-1:0]    span;
    logic               repel;
    logic               near;
    logic               applied;
  } ppf_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [SQ_W-1:0]  span;
    logic             neg;
    logic             applied;
  } ppf_num_t;

  typedef struct packed {
    logic [Q_W-1:0] quot;
    logic           neg;
    logic           applied;
  } ppf_quo_t;

endpackage

// ===== hw/rtl/ppf_geom.sv =====
module ppf_geom import ppf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ppf_req_t         req_i,
  output logic             valid_o,
  output ppf_geo_t         geo_o,
  output logic [RAD_W-1:0] rad_o
);

  logic               v1_q, v2_q, v3_q;
  ppf_geo_t           g1_q, g2_q, g3_q;
  logic [33:0]        sqx_q, sqy_q;
  logic [RAD_W-1:0]   rad_q;
  logic [33:0]        q_sum;
  ppf_geo_t           g1_d, g3_d;

  always_comb begin
    g1_d            = '0;
    g1_d.dx         = $signed({req_i.other_x[15], req_i.other_x})
                    - $signed({req_i.self_x[15], req_i.self_x});
    g1_d.dy         = $signed({req_i.other_y[15], req_i.other_y})
                    - $signed({req_i.self_y[15], req_i.self_y});
    g1_d.self_kind  = req_i.self_kind;
    g1_d.other_kind = req_i.other_kind;
  end

  always_comb begin
    q_sum      = sqx_q + sqy_q;
    g3_d       = g2_q;
    g3_d.zero  = (q_sum == '0);
    g3_d.repel = (q_sum < REPEL_Q);
    g3_d.near  = (q_sum <= NEAR_Q) && (q_sum != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g1_q  <= g1_d;
    sqx_q <= g1_q.dx * g1_q.dx;
    sqy_q <= g1_q.dy * g1_q.dy;
    g2_q  <= g1_q;
    g3_q  <= g3_d;
    rad_q <= g3_d.near ? {1'b0, q_sum[20:0], 24'b0} : '0;
  end

  assign valid_o = v3_q;
  assign geo_o   = g3_q;
  assign rad_o   = rad_q;

endmodule

// ===== hw/rtl/ppf_sqrt.sv =====
module ppf_sqrt import ppf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ppf_geo_t         geo_i,
  input  logic [RAD_W-1:0] rad_i,
  output logic             valid_o,
  output ppf_geo_t         geo_o,
  output logic [SQ_W-1:0]  dist_o
);

  logic             v_q [SQ_W];
  logic [RAD_W-1:0] n_q [SQ_W];
  logic [RAD_W-1:0] r_q [SQ_W];
  ppf_geo_t         g_q [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    localparam int SH = 2 * (SQ_W - 1 - k);
    logic             vin;
    logic [RAD_W-1:0] nin, rin, bitv, n_d, r_d;
    logic [RAD_W:0]   trial;
    ppf_geo_t         gin;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign nin = rad_i;
      assign rin = '0;
      assign gin = geo_i;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign nin = n_q[k-1];
      assign rin = r_q[k-1];
      assign gin = g_q[k-1];
    end

    always_comb begin
      bitv  = RAD_W'(1) << SH;
      trial = {1'b0, rin} + {1'b0, bitv};
      if ({1'b0, nin} >= trial) begin
        n_d = nin - trial[RAD_W-1:0];
        r_d = (rin >> 1) + bitv;
      end else begin
        n_d = nin;
        r_d = rin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[k] <= n_d;
      r_q[k] <= r_d;
      g_q[k] <= gin;
    end
  end

  assign valid_o = v_q[SQ_W-1];
  assign geo_o   = g_q[SQ_W-1];
  assign dist_o  = r_q[SQ_W-1][SQ_W-1:0];

endmodule

// ===== hw/rtl/ppf_force.sv =====
module ppf_force import ppf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ppf_geo_t           geo_i,
  input  logic [SQ_W-1:0]    dist_i,
  input  logic signed [15:0] rule_i,
  input  logic [15:0]        speed_i,
  output logic               valid_o,
  output ppf_num_t           num_x_o,
  output ppf_num_t           num_y_o
);

  logic               v_q [FORCE_STAGES];
  ppf_side_t          s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  ppf_side_t          s1_d;

  logic [20:0]        num_q;
  logic signed [19:0] repf1_q, repf2_q, repf3_q;
  logic signed [15:0] rule1_q, rule2_q;
  logic [42:0]        prod_q;
  logic signed [33:0] rc_q;
  logic [18:0]        mag_q;
  logic               fneg4_q;
  logic [34:0]        fs_q;
  logic [15:0]        adx_q, ady_q;
  logic               xneg5_q, yneg5_q, xneg6_q, yneg6_q;
  logic [33:0]        pxl_q, pyl_q;
  logic [32:0]        pxh_q, pyh_q;
  ppf_num_t           nx_q, ny_q;

  logic signed [24:0] offs;
  logic [23:0]        off;
  logic [23:0]        num_w;
  logic signed [21:0] repf_w;
  logic [16:0]        curve;
  logic signed [33:0] rsh;
  logic signed [19:0] force_w;
  logic [50:0]        sumx, sumy;

  always_comb begin
    s1_d         = '0;
    s1_d.dx      = geo_i.dx;
    s1_d.dy      = geo_i.dy;
    s1_d.span    = geo_i.near ? dist_i : SQ_W'(1);
    s1_d.repel   = geo_i.repel;
    s1_d.near    = geo_i.near;
    s1_d.applied = !geo_i.zero;
    offs         = $signed({2'b0, dist_i}) - $signed({1'b0, FIFTY_Q16});
    off          = offs[24] ? 24'(-offs) : offs[23:0];
    num_w        = THIRTY_Q16 - off;
    repf_w       = $signed({1'b0, dist_i[SQ_W-1:2]}) - $signed(22'(FIVE_Q16));
  end

  always_comb begin
    curve = prod_q[RECIP_SH+16:RECIP_SH];
    rsh   = rc_q >>> 14;
    if (s3_q.repel) begin
      force_w = repf3_q;
    end else if (s3_q.near) begin
      force_w = rsh[19:0];
    end else begin
      force_w = '0;
    end
    sumx = {pxh_q, 18'b0} + {17'b0, pxl_q};
    sumy = {pyh_q, 18'b0} + {17'b0, pyl_q};
  end

  for (genvar k = 0; k < FORCE_STAGES; k++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (k == 0) begin
        v_q[k] <= valid_i;
      end else begin
        v_q[k] <= v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    num_q   <= num_w[20:0];
    repf1_q <= repf_w[19:0];
    rule1_q <= rule_i;

    s2_q    <= s1_q;
    prod_q  <= num_q * RECIP30;
    repf2_q <= repf1_q;
    rule2_q <= rule1_q;

    s3_q    <= s2_q;
    rc_q    <= rule2_q * $signed({1'b0, curve});
    repf3_q <= repf2_q;

    s4_q    <= s3_q;
    mag_q   <= force_w[19] ? 19'(-force_w) : force_w[18:0];
    fneg4_q <= force_w[19];

    s5_q    <= s4_q;
    fs_q    <= mag_q * speed_i;
    adx_q   <= s4_q.dx[16] ? 16'(-s4_q.dx) : s4_q.dx[15:0];
    ady_q   <= s4_q.dy[16] ? 16'(-s4_q.dy) : s4_q.dy[15:0];
    xneg5_q <= s4_q.dx[16] ^ fneg4_q;
    yneg5_q <= s4_q.dy[16] ^ fneg4_q;

    s6_q    <= s5_q;
    pxl_q   <= adx_q * fs_q[17:0];
    pxh_q   <= adx_q * fs_q[34:18];
    pyl_q   <= ady_q * fs_q[17:0];
    pyh_q   <= ady_q * fs_q[34:18];
    xneg6_q <= xneg5_q;
    yneg6_q <= yneg5_q;

    nx_q.num     <= {sumx, 4'b0};
    nx_q.span    <= s6_q.span;
    nx_q.neg     <= xneg6_q;
    nx_q.applied <= s6_q.applied;
    ny_q.num     <= {sumy, 4'b0};
    ny_q.span    <= s6_q.span;
    ny_q.neg     <= yneg6_q;
    ny_q.applied <= s6_q.applied;
  end

  assign valid_o = v_q[FORCE_STAGES-1];
  assign num_x_o = nx_q;
  assign num_y_o = ny_q;

endmodule

// ===== hw/rtl/ppf_div.sv =====
module ppf_div import ppf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  ppf_num_t num_i,
  output logic     valid_o,
  output ppf_quo_t quo_o
);

  logic            v_q    [Q_W];
  logic [SQ_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]  low_q  [Q_W];
  logic [Q_W-1:0]  quot_q [Q_W];
  logic [SQ_W-1:0] d_q    [Q_W];
  logic            neg_q  [Q_W];
  logic            app_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic            vin, negin, appin, ge;
    logic [SQ_W-1:0] remin, din, rem_d;
    logic [Q_W-1:0]  lowin, quotin;
    logic [SQ_W:0]   cand;

    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign remin  = num_i.num[Q_W+SQ_W-1:Q_W];
      assign lowin  = num_i.num[Q_W-1:0];
      assign quotin = '0;
      assign din    = num_i.span;
      assign negin  = num_i.neg;
      assign appin  = num_i.applied;
    end else begin : g_next
      assign vin    = v_q[k-1];
      assign remin  = rem_q[k-1];
      assign lowin  = low_q[k-1];
      assign quotin = quot_q[k-1];
      assign din    = d_q[k-1];
      assign negin  = neg_q[k-1];
      assign appin  = app_q[k-1];
    end

    always_comb begin
      cand  = {remin, lowin[Q_W-1]};
      ge    = (cand >= {1'b0, din});
      rem_d = ge ? SQ_W'(cand - {1'b0, din}) : cand[SQ_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      low_q[k]  <= lowin << 1;
      quot_q[k] <= {quotin[Q_W-2:0], ge};
      d_q[k]    <= din;
      neg_q[k]  <= negin;
      app_q[k]  <= appin;
    end
  end

  assign valid_o       = v_q[Q_W-1];
  assign quo_o.quot    = quot_q[Q_W-1];
  assign quo_o.neg     = neg_q[Q_W-1];
  assign quo_o.applied = app_q[Q_W-1];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Q_W-1] |-> rem_q[Q_W-1] < d_q[Q_W-1])
    else $error("division remainder not below divisor");

  a_first_rem_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> rem_q[0] < d_q[0])
    else $error("quotient exceeds its width");

endmodule

// ===== hw/rtl/pairwise_particle_force_core.sv =====
// accepted requests pass geom, sqrt, force and div stages to done_o
// throughput: one request per cycle, busy is never raised
// the 23-stage square root and the two 27-stage dividers set the depth
// the receiver cannot stall, so the pipeline never holds
// reset clears all valid bits, the rules to zero and speed gain to 1.0
module pairwise_particle_force_core import ppf_pkg::*; #(
  parameter int NUM_KINDS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ppf_req_t             req_i,
  output logic                 done_o,
  output ppf_res_t             res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int KW  = $clog2(NUM_KINDS);
  localparam int LAT = GEOM_STAGES + SQ_W + FORCE_STAGES + Q_W + 1;

  logic [63:0]        rule_q [NUM_KINDS];
  logic [15:0]        speed_q;
  logic               acc;

  logic               geo_v, sq_v, frc_v, divx_v, divy_v;
  ppf_geo_t           geo, sq_geo;
  logic [RAD_W-1:0]   rad;
  logic [SQ_W-1:0]    span;
  logic signed [15:0] rule;
  logic [63:0]        row;
  ppf_num_t           num_x, num_y;
  ppf_quo_t           quo_x, quo_y;

  logic               done_q;
  ppf_res_t           res_q, res_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KINDS; i++) begin
        rule_q[i] <= '0;
      end
      speed_q <= SPEED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i < CFG_IDX_W'(NUM_KINDS)) begin
        rule_q[cfg_index_i[KW-1:0]] <= cfg_data_i;
      end else if (cfg_index_i == CFG_SPEED) begin
        speed_q <= cfg_data_i[15:0];
      end
    end
  end

  ppf_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .req_i   (req_i),
    .valid_o (geo_v),
    .geo_o   (geo),
    .rad_o   (rad)
  );

  ppf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geo_v),
    .geo_i   (geo),
    .rad_i   (rad),
    .valid_o (sq_v),
    .geo_o   (sq_geo),
    .dist_o  (span)
  );

  // kinds outside the table read as a zero rule
  always_comb begin
    row  = '0;
    rule = '0;
    if (({1'b0, sq_geo.self_kind} < 3'(NUM_KINDS))
        && ({1'b0, sq_geo.other_kind} < 3'(NUM_KINDS))) begin
      row  = rule_q[sq_geo.self_kind[KW-1:0]];
      rule = row[{sq_geo.other_kind, 4'b0} +: 16];
    end
  end

  ppf_force u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .geo_i   (sq_geo),
    .dist_i  (span),
    .rule_i  (rule),
    .speed_i (speed_q),
    .valid_o (frc_v),
    .num_x_o (num_x),
    .num_y_o (num_y)
  );

  ppf_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (frc_v),
    .num_i   (num_x),
    .valid_o (divx_v),
    .quo_o   (quo_x)
  );

  ppf_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (frc_v),
    .num_i   (num_y),
    .valid_o (divy_v),
    .quo_o   (quo_y)
  );

  // quotient magnitude stays below 2^27, so the result never clamps
  always_comb begin
    res_d.accel_x = quo_x.neg ? -32'(quo_x.quot) : 32'(quo_x.quot);
    res_d.accel_y = quo_y.neg ? -32'(quo_y.quot) : 32'(quo_y.quot);
    res_d.applied = quo_x.applied;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= divx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divx_v == divy_v)
    else $error("divider lanes out of step");

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o)
    else $error("request did not complete at fixed latency");

  a_coincide_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.applied |-> res_o.accel_x == '0 && res_o.accel_y == '0)
    else $error("force on coinciding positions");

endmodule

// ===== tb/sv/pairwise_particle_force_checker.sv =====
module pairwise_particle_force_checker import ppf_pkg::*; #(
  parameter int NUM_KINDS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  ppf_req_t             req_i,
  input  logic                 done_i,
  input  ppf_res_t             res_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output int                   pending_o,
  output int                   errors_o
);

  logic [63:0] rule_row [4];
  logic [15:0] speed_gain;
  ppf_res_t    accel_q [$];

  assign pending_o = accel_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_word(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic ppf_res_t predict_accel(ppf_req_t p);
    ppf_res_t r;
    longint dx, dy, q, span, force_v, rule, off, curve, spd;
    r = '0;
    dx = longint'(p.other_x) - longint'(p.self_x);
    dy = longint'(p.other_y) - longint'(p.self_y);
    q = dx * dx + dy * dy;
    if (q == 0) return r;
    span = longint'(int_sqrt(longint'(q) << 24));
    force_v = 0;
    spd = longint'({48'd0, speed_gain});
    if (q < 102400) begin
      force_v = (span >>> 2) - (longint'(5) << 16);
    end else if (q <= 1638400) begin
      rule = 0;
      if (p.self_kind < NUM_KINDS && p.other_kind < NUM_KINDS)
        rule = longint'($signed(rule_row[p.self_kind][16*p.other_kind +: 16]));
      off = span - (longint'(50) << 16);
      if (off < 0) off = -off;
      curve = ((longint'(30) << 16) - off) / 30;
      force_v = (rule * curve) >>> 14;
    end
    r.accel_x = sat_word((dx * force_v * spd * 16) / span);
    r.accel_y = sat_word((dy * force_v * spd * 16) / span);
    r.applied = 1'b1;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ppf_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) rule_row[i] = '0;
      speed_gain = SPEED_RESET;
      accel_q.delete();
      errors_o = 0;
    end else begin
      if (done_i) begin
        if (accel_q.size() == 0) begin
          report("unexpected done", 1, 0);
        end else begin
          want = accel_q.pop_front();
          if (res_i.accel_x !== want.accel_x) report("accel_x", res_i.accel_x, want.accel_x);
          if (res_i.accel_y !== want.accel_y) report("accel_y", res_i.accel_y, want.accel_y);
          if (res_i.applied !== want.applied) report("applied", res_i.applied, want.applied);
        end
      end
      if (start_i && !busy_i) accel_q.push_back(predict_accel(req_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i < CFG_SPEED) rule_row[cfg_index_i[1:0]] = cfg_data_i;
        else if (cfg_index_i == CFG_SPEED) speed_gain = cfg_data_i[15:0];
      end
    end
  end

endmodule

// ===== tb/sv/pairwise_particle_force_core_tb.sv =====
module pairwise_particle_force_core_tb import ppf_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST      = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  ppf_req_t             req = '0;
  logic                 done;
  ppf_res_t             res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  int                   pending;
  int                   errors;
  int                   quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pairwise_particle_force_core i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .req_i(req),
    .done_o(done), .res_o(res), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pairwise_particle_force_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .req_i(req),
    .done_i(done), .res_i(res), .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .pending_o(pending),
    .errors_o(errors)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pair(ppf_req_t p);
    logic b;
    start <= 1'b1;
    req   <= p;
    forever begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
      if (!b) break;
    end
  endtask

  // leaves valid high so writes can follow back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    logic r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
      if (r) break;
    end
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic ppf_req_t make_pair(int sx, int sy, int ox, int oy, int n);
    ppf_req_t p;
    p.self_x = 16'(sx);
    p.self_y = 16'(sy);
    p.other_x = 16'(ox);
    p.other_y = 16'(oy);
    p.self_kind = 2'(n);
    p.other_kind = 2'(n >> 2);
    return p;
  endfunction

  function automatic ppf_req_t random_pair();
    ppf_req_t p;
    int mode;
    p = ppf_req_t'({$urandom, $urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode >= 2) begin
      p.other_x = p.self_x + 16'($signed($urandom_range(0, 2800)) - 1400);
      p.other_y = p.self_y + 16'($signed($urandom_range(0, 2800)) - 1400);
    end
    if (mode == 9) begin
      p.other_x = p.self_x;
      p.other_y = p.self_y;
    end
    return p;
  endfunction

  initial begin
    logic [63:0] rows;
    logic [15:0] gain;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      repeat (70) @(posedge clk);
      for (logic [CFG_IDX_W-1:0] i = CFG_ROW_ZERO; i <= CFG_ROW_THREE; i++) begin
        case (ph)
          2: rows = {4{16'h8000}};
          3: rows = {4{16'h7fff}};
          default: rows = {$urandom, $urandom};
        endcase
        write_reg(i, rows);
      end
      case (ph)
        2: gain = 16'hffff;
        3: gain = 16'h0000;
        4: gain = 16'h0001;
        5: gain = 16'h0100;
        default: gain = 16'($urandom);
      endcase
      write_reg(CFG_SPEED, {$urandom, $urandom});
      write_reg(CFG_SPEED, {48'($urandom), gain});
      if (ph == 5) begin
        for (logic [CFG_IDX_W-1:0] i = CFG_SPEED + 3'd1; i != 0 && i <= CFG_LAST; i++)
          write_reg(i, {$urandom, $urandom});
      end
      cfg_valid <= 1'b0;
      if (ph == 0) begin
        send_pair(make_pair(100, 100, 100, 100, 0));
        send_pair(make_pair(0, 0, 1, 0, 1));
        send_pair(make_pair(0, 0, 319, 0, 2));
        send_pair(make_pair(0, 0, 320, 0, 3));
        send_pair(make_pair(0, 0, 192, 256, 4));
        send_pair(make_pair(0, 0, 800, 0, 5));
        send_pair(make_pair(0, 0, 0, -1280, 6));
        send_pair(make_pair(0, 0, 1280, 0, 7));
        send_pair(make_pair(0, 0, 1281, 0, 8));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 9));
        send_pair(make_pair(32767, 32767, -32768, -32768, 10));
        send_pair(make_pair(32767, -32768, 32767, -32768, 11));
        send_pair(make_pair(-32768, 0, -32268, -400, 12));
        send_pair(make_pair(500, -700, 100, -900, 13));
        send_pair(make_pair(-50, 20, 600, -500, 14));
        send_pair(make_pair(7, 9, -600, 300, 15));
      end
      for (int k = 0; k < 160; k++) begin
        if (ph < 5 && $urandom_range(0, 7) == 0) idle_burst();
        send_pair(random_pair());
      end
      start <= 1'b0;
    end
    drain();
    repeat (70) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ppf_pkg.sv
hw/rtl/ppf_geom.sv
hw/rtl/ppf_sqrt.sv
hw/rtl/ppf_force.sv
hw/rtl/ppf_div.sv
hw/rtl/pairwise_particle_force_core.sv
tb/sv/pairwise_particle_force_checker.sv
tb/sv/pairwise_particle_force_core_tb.sv
